/* design/sss_pkg.sv */
// shared constants, types and segment table for the seven-segment scanner
package sss_pkg;

  localparam int SCALE_SHIFT = 10;
  localparam int SAMPLE_W    = 10;
  localparam int GAIN_W      = 14;
  localparam int VALUE_W     = 14;
  localparam int SLOT_W      = 3;
  localparam int DIGITS      = 4;
  localparam int DIGIT_W     = 4;
  localparam int SEG_W       = 8;
  localparam int RECIP_W     = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(50);

  // item codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register word index
  localparam logic REG_SCALE_GAIN = 1'b0;

  // scan slots: zero is the blank slot, one to four select a digit
  localparam logic [SLOT_W-1:0] SLOT_BLANK = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(DIGITS);

  localparam logic [SEG_W-1:0]   SEG_BLANK     = 8'hFF;
  localparam logic [SEG_W-1:0]   SEG_DP_MASK   = 8'hFE;
  localparam logic [DIGITS-1:0]  ENABLE_BLANK  = 4'b1000;

  typedef struct packed {
    logic [DIGITS-1:0] digit_enable;
    logic [SEG_W-1:0]  segments;
  } display_t;

  // active-low segment pattern for one decimal digit
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h03;
      4'd1:    s = 8'h9F;
      4'd2:    s = 8'h25;
      4'd3:    s = 8'h0D;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h49;
      4'd6:    s = 8'h41;
      4'd7:    s = 8'h1B;
      4'd8:    s = 8'h01;
      4'd9:    s = 8'h09;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // ceil(2^32 / 10^(pos+1)): the fractional part of value*recip gives the digit
  function automatic logic [RECIP_W-1:0] digit_recip(input logic [1:0] pos);
    logic [RECIP_W-1:0] r;
    case (pos)
      2'd0:    r = 32'd429496730;
      2'd1:    r = 32'd42949673;
      2'd2:    r = 32'd4294968;
      default: r = 32'd429497;
    endcase
    return r;
  endfunction

endpackage

/* design/sss_segment_encoder.sv */
// picks one decimal digit of the shown value and maps it to a segment pattern
module sss_segment_encoder (
  input  logic [sss_pkg::VALUE_W-1:0] value,
  input  logic [sss_pkg::SLOT_W-1:0]  slot,
  output sss_pkg::display_t           display
);

  localparam int PROD_W = sss_pkg::VALUE_W + sss_pkg::RECIP_W;

  logic [1:0]                    pos;
  logic [PROD_W-1:0]             prod;
  logic [sss_pkg::RECIP_W-1:0]   frac;
  logic [sss_pkg::RECIP_W+3:0]   times10;
  logic [sss_pkg::DIGIT_W-1:0]   digit;
  logic [sss_pkg::SEG_W-1:0]     seg;

  assign pos  = 2'(slot - sss_pkg::SLOT_W'(1));
  assign prod = PROD_W'(value) * PROD_W'(sss_pkg::digit_recip(pos));
  assign frac = prod[sss_pkg::RECIP_W-1:0];
  // frac * 10 by shift and add, the integer part is the digit
  assign times10 = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
  assign digit   = times10[sss_pkg::RECIP_W+3:sss_pkg::RECIP_W];
  assign seg     = sss_pkg::seg_code(digit);

  always_comb begin
    if (slot == sss_pkg::SLOT_BLANK) begin
      display.digit_enable = sss_pkg::ENABLE_BLANK;
      display.segments     = sss_pkg::SEG_BLANK;
    end else begin
      display.digit_enable = sss_pkg::DIGITS'(1) << pos;
      // thousands digit carries the decimal point
      display.segments     = (pos == 2'd3) ? (seg & sss_pkg::SEG_DP_MASK) : seg;
    end
  end

endmodule

/* design/scaled_seven_segment_scanner_top.sv */
// top level of the scaled seven-segment scanner
// Takes one item per clock while item_ready is high: a sample item rescales
// the shown value to (sample * scale_gain) >> SCALE_SHIFT, saturated to 14
// bits, and gives no result; a scan tick steps the five-slot scan and gives
// one result with the digit enable and active-low segments. An item passes
// the input register and then the result register; a tick holds in the input
// register while a result waits unaccepted, and the input side keeps taking
// items while a result waits as long as the input register holds no tick.
module scaled_seven_segment_scanner_top #(
  parameter int SCALE_SHIFT = sss_pkg::SCALE_SHIFT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sss_pkg::ADDR_W-1:0]     paddr,
  input  logic [sss_pkg::DATA_W-1:0]     pwdata,
  output logic [sss_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           opcode,
  input  logic [sss_pkg::SAMPLE_W-1:0]   sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [sss_pkg::DIGITS-1:0]     digit_enable,
  output logic [sss_pkg::SEG_W-1:0]      segments
);

  localparam int PROD_W = sss_pkg::SAMPLE_W + sss_pkg::GAIN_W;

  logic [sss_pkg::GAIN_W-1:0]   scale_gain;
  logic [sss_pkg::SLOT_W-1:0]   scan_slot;
  logic [sss_pkg::SLOT_W-1:0]   scan_slot_next;
  logic [sss_pkg::SLOT_W-1:0]   slot_step;
  logic [sss_pkg::VALUE_W-1:0]  shown_value;
  logic [sss_pkg::VALUE_W-1:0]  scaled;
  logic [PROD_W-1:0]            product;
  logic [PROD_W-1:0]            shifted;

  logic                         s1_valid;
  logic                         s1_opcode;
  logic [sss_pkg::SAMPLE_W-1:0] s1_sample;
  logic                         s1_advance;
  logic                         s1_tick;
  logic                         cfg_write;
  sss_pkg::display_t            display;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready &
                     (paddr[2] == sss_pkg::REG_SCALE_GAIN);

  always_comb begin
    if (paddr[2] == sss_pkg::REG_SCALE_GAIN) begin
      prdata = sss_pkg::DATA_W'(scale_gain);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_gain <= sss_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      scale_gain <= pwdata[sss_pkg::GAIN_W-1:0];
    end
  end

  // input stage; a tick holds only while the result register is full and stalled
  assign s1_tick    = s1_valid & (s1_opcode == sss_pkg::OP_TICK);
  assign s1_advance = !s1_tick || !result_valid || result_ready;
  assign item_ready = s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s1_opcode <= opcode;
      s1_sample <= sample;
    end
  end

  // sample scaling, saturated to the display width
  assign product = PROD_W'(s1_sample) * PROD_W'(scale_gain);
  assign shifted = product >> SCALE_SHIFT;
  assign scaled  = (|shifted[PROD_W-1:sss_pkg::VALUE_W]) ? '1
                                                         : shifted[sss_pkg::VALUE_W-1:0];

  // scan slot step, anything past the last digit is the blank slot
  assign slot_step = scan_slot + sss_pkg::SLOT_W'(1);
  assign scan_slot_next = (slot_step != sss_pkg::SLOT_BLANK && slot_step <= sss_pkg::SLOT_LAST)
                          ? slot_step : sss_pkg::SLOT_BLANK;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_slot   <= sss_pkg::SLOT_BLANK;
      shown_value <= '0;
    end else if (s1_valid && s1_advance) begin
      if (s1_opcode == sss_pkg::OP_SAMPLE) begin
        shown_value <= scaled;
      end else begin
        scan_slot <= scan_slot_next;
      end
    end
  end

  sss_segment_encoder u_encoder (
    .value   (shown_value),
    .slot    (scan_slot_next),
    .display (display)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_tick && s1_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_tick && s1_advance) begin
      digit_enable <= display.digit_enable;
      segments     <= display.segments;
    end
  end

endmodule

/* design/sss_checker.sv */
// port-level checks for the seven-segment scanner, bound to the top level
module sss_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [sss_pkg::DIGITS-1:0] digit_enable,
  input logic [sss_pkg::SEG_W-1:0]  segments
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(digit_enable) && $stable(segments))
    else $error("result changed while stalled");

  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot(digit_enable))
    else $error("digit enable not one-hot");

  // only the thousands digit may light the decimal point
  a_dp_thousands: assert property (@(posedge clk) disable iff (rst)
    result_valid && !digit_enable[3] |-> segments[0])
    else $error("decimal point lit on a lower digit");

  // thousands enable without the decimal point is the blank slot
  a_blank_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && digit_enable[3] && segments[0] |-> segments == sss_pkg::SEG_BLANK)
    else $error("blank slot not fully dark");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind scaled_seven_segment_scanner_top sss_checker u_sss_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .digit_enable (digit_enable),
  .segments     (segments)
);

/* dv/scaled_seven_segment_scanner_top_tb.sv */
// testbench for the scaled seven-segment scanner: directed table, then random phases per gain
module scaled_seven_segment_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int SHIFT = sss_pkg::SCALE_SHIFT;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASES = 6;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1B, 8'h01, 8'h09
  };

  typedef struct packed {
    logic     op;
    logic [SAMPLE_W-1:0] smp;
    bit       typed;
    display_t fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic item_valid, item_ready;
  logic opcode;
  logic [SAMPLE_W-1:0] sample;
  logic result_valid, result_ready;
  logic [DIGITS-1:0] digit_enable;
  logic [SEG_W-1:0] segments;

  // display model state
  logic [GAIN_W-1:0]  gain_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [VALUE_W-1:0] shown_q;

  display_t  pending_display[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int samples_sent = 0;

  scaled_seven_segment_scanner_top #(.SCALE_SHIFT(SHIFT)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .opcode(opcode), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready),
    .digit_enable(digit_enable), .segments(segments)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the display model by one item; returns 1 when a scan output is produced
  function automatic bit scan_apply(input logic op, input logic [SAMPLE_W-1:0] smp,
                                    output display_t res);
    int unsigned prod;
    int unsigned v;
    int pos;
    logic [SLOT_W-1:0] nxt;
    res = '0;
    if (op == OP_SAMPLE) begin
      prod = (int'(smp) * int'(gain_q)) >> SHIFT;
      shown_q = (prod > int'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(prod);
      return 1'b0;
    end
    nxt = slot_q + 1'b1;
    if (nxt >= 1 && nxt <= SLOT_LAST) begin
      pos = int'(nxt) - 1;
      v = int'(shown_q) % 10000;
      for (int k = 0; k < pos; k++) v = v / 10;
      res.segments = DIGIT_SEG[v % 10];
      if (pos == DIGITS - 1) res.segments = res.segments & SEG_DP_MASK;
      res.digit_enable = DIGITS'(1) << pos;
      slot_q = nxt;
    end else begin
      res.digit_enable = ENABLE_BLANK;
      res.segments = SEG_BLANK;
      slot_q = SLOT_BLANK;
    end
    return 1'b1;
  endfunction

  task automatic add_row(input logic op, input int smp, input bit typed,
                         input logic [DIGITS-1:0] en, input logic [SEG_W-1:0] seg);
    stim_row_t r;
    r.op = op;
    r.smp = SAMPLE_W'(smp);
    r.typed = typed;
    r.fixed.digit_enable = en;
    r.fixed.segments = seg;
    directed_rows.push_back(r);
  endtask

  // holds valid until transfer; leaves valid high for the caller
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp,
                           input bit typed, input display_t fixed);
    display_t res;
    item_valid <= 1'b1;
    opcode <= op;
    sample <= smp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (scan_apply(op, smp, res)) begin
      pending_display.push_back(typed ? fixed : res);
      ticks_sent++;
    end else begin
      samples_sent++;
    end
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(REG_SCALE_GAIN));
    // upper bits are noise and must be dropped
    pwdata <= {DATA_W'($urandom) & ~DATA_W'((1 << GAIN_W) - 1)} | DATA_W'(g);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gain_q = g;
  endtask

  task automatic drain();
    while (pending_display.size() != 0) @(posedge clk);
    // a trailing sample gives no result but may still be in flight
    repeat (8) @(posedge clk);
  endtask

  // receiver: result_ready follows a stall pattern drawn at random from four modes
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    display_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_display.size() == 0) begin
        $display("%0t: result transfer with nothing expected: en=%h seg=%h",
                 $time, digit_enable, segments);
        mismatches++;
      end else begin
        want = pending_display.pop_front();
        if (digit_enable !== want.digit_enable) begin
          $display("%0t: digit_enable expected %h actual %h",
                   $time, want.digit_enable, digit_enable);
          mismatches++;
        end
        if (segments !== want.segments) begin
          $display("%0t: segments expected %h actual %h", $time, want.segments, segments);
          mismatches++;
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= 1'($urandom_range(0, 1));
      2: result_ready <= (rx_cycle % 5 == 0);
      default: result_ready <= rx_cycle[4];
    endcase
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    display_t none;
    int burst;
    int gap;
    int pick;
    logic op;
    logic [SAMPLE_W-1:0] smp;
    logic [GAIN_W-1:0] g;

    none = '0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_valid <= 1'b0;
    opcode <= OP_TICK;
    sample <= '0;
    gain_q = GAIN_RESET;
    slot_q = SLOT_BLANK;
    shown_q = '0;

    // full scan of a zero display after reset
    add_row(OP_TICK, 0, 1, 4'b0001, 8'h03);
    add_row(OP_TICK, 1023, 1, 4'b0010, 8'h03);
    add_row(OP_TICK, 0, 1, 4'b0100, 8'h03);
    add_row(OP_TICK, 0, 1, 4'b1000, 8'h02);
    add_row(OP_TICK, 0, 1, ENABLE_BLANK, SEG_BLANK);
    add_row(OP_SAMPLE, 1023, 0, 0, 0);
    repeat (5) add_row(OP_TICK, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 0, 0, 0, 0);
    add_row(OP_TICK, 0, 1, 4'b0001, 8'h03);
    add_row(OP_SAMPLE, 512, 0, 0, 0);
    add_row(OP_TICK, 682, 0, 0, 0);
    // new value lands mid-scan
    add_row(OP_SAMPLE, 21, 0, 0, 0);
    add_row(OP_TICK, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 1, 0, 0, 0);
    add_row(OP_SAMPLE, 700, 0, 0, 0);
    repeat (4) add_row(OP_TICK, 341, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].typed,
                directed_rows[i].fixed);
      if ($urandom_range(0, 2) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    item_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: g = '1;
        1: g = '0;
        2: g = GAIN_W'(1);
        5: g = '1;
        default: g = GAIN_W'($urandom);
      endcase
      write_gain(g);
      @(posedge clk);
      burst = $urandom_range(1, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 9) < 3) ? OP_SAMPLE : OP_TICK;
        pick = $urandom_range(0, 9);
        smp = (pick == 0) ? '0 : (pick == 1) ? '1 : SAMPLE_W'($urandom);
        send_item(op, smp, 1'b0, none);
        burst--;
        if (burst == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 40);
        end
      end
      item_valid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d scan ticks and %0d samples over %0d gain settings",
             ticks_sent, samples_sent, PHASES + 1);
    $display("gain extremes 0 and max included, with random stalls on both channels");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
